FILE: rtl/bcba_pkg.sv
// Shared constants, types and codes of the bitmap block allocator.
package bcba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int WORD_W     = 8;
  localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
  localparam int ADDR_W     = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;
  localparam int RNG_W      = CNT_W + 1;
  localparam int POP_W      = $clog2(WORD_W + 1);
  localparam int FRAC_W     = 15;
  localparam int NUM_W      = CNT_W + FRAC_W;
  localparam int ITER_W     = $clog2(NUM_W);
  localparam int PCT_SCALE  = 25600;

  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_FIND_END,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_LONG,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic en;
    logic find;
  } scan_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] start;
    logic [CNT_W-1:0] best;
  } scan_res_t;

endpackage

FILE: rtl/bcba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bcba_scan.sv
// Run scanner: walks one map word per step, tracking free runs and first fit.
module bcba_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bcba_pkg::scan_ctrl_t      ctrl_i,
  input  logic [bcba_pkg::WORD_W-1:0] word_i,
  input  logic [bcba_pkg::ADDR_W-1:0] base_i,
  input  logic [bcba_pkg::CNT_W-1:0]  need_i,
  output bcba_pkg::scan_res_t       res_o
);

  logic [bcba_pkg::CNT_W-1:0] cur_q, cur_d;
  logic [bcba_pkg::CNT_W-1:0] best_q, best_d;
  logic                       found_q, found_d;
  logic [bcba_pkg::BLK_W-1:0] start_q, start_d;
  logic [bcba_pkg::CNT_W-1:0] blk;

  always_comb begin
    cur_d   = cur_q;
    best_d  = best_q;
    found_d = found_q;
    start_d = start_q;
    blk     = '0;
    for (int b = 0; b < bcba_pkg::WORD_W; b++) begin
      blk = {1'b0, base_i, bcba_pkg::BIT_W'(b)};
      if (word_i[b]) begin
        cur_d = '0;
      end else begin
        cur_d = cur_d + 1'b1;
      end
      if (cur_d > best_d) begin
        best_d = cur_d;
      end
      if (ctrl_i.find && !found_d && !word_i[b] && (cur_d == need_i)) begin
        found_d = 1'b1;
        start_d = bcba_pkg::BLK_W'(blk + bcba_pkg::CNT_W'(1) - need_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
      start_q <= '0;
    end else if (ctrl_i.clr) begin
      cur_q   <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
      start_q <= '0;
    end else if (ctrl_i.en) begin
      cur_q   <= cur_d;
      best_q  <= best_d;
      found_q <= found_d;
      start_q <= start_d;
    end
  end

  assign res_o.found = found_q;
  assign res_o.start = start_q;
  assign res_o.best  = best_q;

endmodule

FILE: rtl/bcba_div.sv
// Restoring divider, one quotient bit per cycle, for the fragmentation figure.
module bcba_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bcba_pkg::NUM_W-1:0]  num_i,
  input  logic [bcba_pkg::CNT_W-1:0]  den_i,
  output logic                        done_o,
  output logic [bcba_pkg::FRAC_W-1:0] quot_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [bcba_pkg::ITER_W-1:0]  iter_q;
  logic [bcba_pkg::NUM_W-1:0]   num_q;
  logic [bcba_pkg::CNT_W-1:0]   den_q;
  logic [bcba_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [bcba_pkg::FRAC_W-1:0]  quot_q;
  logic [bcba_pkg::CNT_W:0]     trial;
  logic                         ge;
  logic                         last;

  assign trial = {rem_q, num_q[bcba_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? bcba_pkg::CNT_W'(trial - {1'b0, den_q}) : bcba_pkg::CNT_W'(trial);
  assign last  = iter_q == bcba_pkg::ITER_W'(bcba_pkg::NUM_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[bcba_pkg::NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[bcba_pkg::FRAC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/bitmap_contiguous_block_allocator_unit.sv
// Top level of the first-fit bitmap block allocator with its sequencer.
//
// Use: a request (func_i, block_count_i, first_block_i) is taken when in_valid_i
// is high and in_stall_o is low; in_stall_o is high from acceptance until the
// sequencer is back in idle. One result per request leaves on out_valid_o and
// is taken when out_stall_i is low.
// Each request walks the 1024-block map, held as 128 words of 8 bits, through
// one shared run scanner at one word per cycle and one RAM read port:
//   every request: the final longest-run walk, a multiply step, a bit-serial
//   divide and the load of the output register;
//   allocate with a non-zero count: a first-fit walk before these;
//   allocate or free that changes the map: a read and a write per 8-block word touched.
// The result waits in an output register; the next request is taken while it
// waits, and a finished request holds in its last step while out_stall_i stays
// high and the register is full.
// Reset marks every block free through per-word valid bits, so no clearing
// pass is needed; free count is 1024, used count 0, no result pending.
module bitmap_contiguous_block_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [bcba_pkg::CNT_W-1:0]  block_count_i,
  input  logic [bcba_pkg::BLK_W-1:0]  first_block_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [bcba_pkg::BLK_W-1:0]  start_block_o,
  output logic [bcba_pkg::CNT_W-1:0]  free_count_o,
  output logic [bcba_pkg::CNT_W-1:0]  used_count_o,
  output logic [bcba_pkg::CNT_W-1:0]  largest_free_run_o,
  output logic [bcba_pkg::FRAC_W-1:0] fragment_pct_o
);

  bcba_pkg::state_e state_q, state_d;

  logic [1:0]                  func_q;
  logic [bcba_pkg::CNT_W-1:0]  cnt_q;
  logic                        ok_q;
  logic [bcba_pkg::BLK_W-1:0]  start_q;
  logic [bcba_pkg::CNT_W-1:0]  free_q;
  logic [bcba_pkg::CNT_W-1:0]  used_q;
  logic [bcba_pkg::BLK_W-1:0]  lo_q;
  logic [bcba_pkg::CNT_W-1:0]  end_q;
  logic [bcba_pkg::ADDR_W-1:0] mw_q;
  logic [bcba_pkg::ADDR_W:0]   scan_cnt_q;
  logic                        scan_pend_q;
  logic [bcba_pkg::ADDR_W-1:0] data_addr_q;
  logic [bcba_pkg::NUM_WORDS-1:0] valid_q;
  logic                        rvalid_q;
  logic [bcba_pkg::CNT_W-1:0]  largest_q;
  logic                        zero_q;

  logic                        out_valid_q;
  logic                        out_ok_q;
  logic [bcba_pkg::BLK_W-1:0]  out_start_q;
  logic [bcba_pkg::CNT_W-1:0]  out_free_q;
  logic [bcba_pkg::CNT_W-1:0]  out_used_q;
  logic [bcba_pkg::CNT_W-1:0]  out_largest_q;
  logic [bcba_pkg::FRAC_W-1:0] out_frag_q;

  logic                        accept;
  logic                        scan_state;
  logic                        scan_last;
  logic                        out_load;
  logic [bcba_pkg::RNG_W-1:0]  range_sum;
  logic                        range_ok;
  logic [bcba_pkg::CNT_W-1:0]  end_m1;
  logic [bcba_pkg::ADDR_W-1:0] last_w;

  logic                        ram_re;
  logic                        ram_we;
  logic [bcba_pkg::ADDR_W-1:0] ram_raddr;
  logic [bcba_pkg::WORD_W-1:0] ram_rdata;
  logic [bcba_pkg::WORD_W-1:0] word;
  logic [bcba_pkg::WORD_W-1:0] mark_mask;
  logic [bcba_pkg::WORD_W-1:0] mark_word;
  logic [bcba_pkg::POP_W-1:0]  cleared;
  logic [bcba_pkg::CNT_W-1:0]  mblk;

  bcba_pkg::scan_ctrl_t        scan_ctrl;
  bcba_pkg::scan_res_t         scan_res;

  logic                        div_start;
  logic                        div_done;
  logic [bcba_pkg::FRAC_W-1:0] div_quot;
  logic [bcba_pkg::CNT_W-1:0]  diff;
  logic [bcba_pkg::NUM_W-1:0]  num;

  assign accept     = in_valid_i && (state_q == bcba_pkg::ST_IDLE);
  assign in_stall_o = state_q != bcba_pkg::ST_IDLE;
  assign scan_state = (state_q == bcba_pkg::ST_FIND) || (state_q == bcba_pkg::ST_LONG);
  assign scan_last  = scan_pend_q && (data_addr_q == bcba_pkg::ADDR_W'(bcba_pkg::NUM_WORDS - 1));
  assign out_load   = (state_q == bcba_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  assign range_sum = {2'b00, first_block_i} + {1'b0, block_count_i};
  assign range_ok  = range_sum <= bcba_pkg::RNG_W'(bcba_pkg::NUM_BLOCKS);
  assign end_m1    = end_q - 1'b1;
  assign last_w    = end_m1[bcba_pkg::BLK_W-1:bcba_pkg::BIT_W];

  assign word = rvalid_q ? ram_rdata : '0;

  always_comb begin
    mark_mask = '0;
    cleared   = '0;
    mblk      = '0;
    for (int b = 0; b < bcba_pkg::WORD_W; b++) begin
      mblk         = {1'b0, mw_q, bcba_pkg::BIT_W'(b)};
      mark_mask[b] = (mblk >= {1'b0, lo_q}) && (mblk < end_q);
      cleared      = cleared + bcba_pkg::POP_W'(mark_mask[b] & word[b]);
    end
    if (func_q == bcba_pkg::FUNC_ALLOC) begin
      mark_word = word | mark_mask;
    end else begin
      mark_word = word & ~mark_mask;
    end
  end

  assign diff = scan_res.best > free_q ? '0 : free_q - scan_res.best;
  assign num  = bcba_pkg::NUM_W'(diff) * bcba_pkg::NUM_W'(bcba_pkg::PCT_SCALE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bcba_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            bcba_pkg::FUNC_ALLOC: begin
              state_d = (block_count_i != '0) ? bcba_pkg::ST_FIND : bcba_pkg::ST_LONG;
            end
            bcba_pkg::FUNC_FREE: begin
              state_d = (range_ok && block_count_i != '0) ? bcba_pkg::ST_MARK_RD
                                                          : bcba_pkg::ST_LONG;
            end
            default: state_d = bcba_pkg::ST_LONG;
          endcase
        end
      end
      bcba_pkg::ST_FIND: begin
        if (scan_last) begin
          state_d = bcba_pkg::ST_FIND_END;
        end
      end
      bcba_pkg::ST_FIND_END: begin
        state_d = scan_res.found ? bcba_pkg::ST_MARK_RD : bcba_pkg::ST_LONG;
      end
      bcba_pkg::ST_MARK_RD: state_d = bcba_pkg::ST_MARK_WR;
      bcba_pkg::ST_MARK_WR: begin
        state_d = (mw_q == last_w) ? bcba_pkg::ST_LONG : bcba_pkg::ST_MARK_RD;
      end
      bcba_pkg::ST_LONG: begin
        if (scan_last) begin
          state_d = bcba_pkg::ST_MUL;
        end
      end
      bcba_pkg::ST_MUL: state_d = bcba_pkg::ST_DIV;
      bcba_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = bcba_pkg::ST_DONE;
        end
      end
      bcba_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = bcba_pkg::ST_IDLE;
        end
      end
      default: state_d = bcba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    ram_raddr      = mw_q;
    scan_ctrl.clr  = 1'b0;
    scan_ctrl.en   = 1'b0;
    scan_ctrl.find = 1'b0;
    div_start      = 1'b0;
    case (state_q)
      bcba_pkg::ST_FIND, bcba_pkg::ST_LONG: begin
        ram_re         = ~scan_cnt_q[bcba_pkg::ADDR_W];
        ram_raddr      = scan_cnt_q[bcba_pkg::ADDR_W-1:0];
        scan_ctrl.en   = scan_pend_q;
        scan_ctrl.find = state_q == bcba_pkg::ST_FIND;
      end
      bcba_pkg::ST_IDLE, bcba_pkg::ST_FIND_END: scan_ctrl.clr = 1'b1;
      bcba_pkg::ST_MARK_RD: begin
        ram_re        = 1'b1;
        scan_ctrl.clr = 1'b1;
      end
      bcba_pkg::ST_MARK_WR: begin
        ram_we        = 1'b1;
        scan_ctrl.clr = 1'b1;
      end
      bcba_pkg::ST_MUL: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= bcba_pkg::CNT_W'(bcba_pkg::NUM_BLOCKS);
      used_q      <= '0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      scan_cnt_q  <= '0;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_pend_q <= scan_state && ram_re;
      if (scan_state) begin
        if (ram_re) begin
          scan_cnt_q <= scan_cnt_q + 1'b1;
        end
      end else begin
        scan_cnt_q <= '0;
      end
      if (ram_re) begin
        rvalid_q <= valid_q[ram_raddr];
      end
      if (ram_we) begin
        valid_q[mw_q] <= 1'b1;
        if (func_q == bcba_pkg::FUNC_FREE) begin
          free_q <= free_q + bcba_pkg::CNT_W'(cleared);
          used_q <= used_q - bcba_pkg::CNT_W'(cleared);
        end
      end
      if ((state_q == bcba_pkg::ST_FIND_END) && scan_res.found) begin
        free_q <= free_q - cnt_q;
        used_q <= used_q + cnt_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_state) begin
      data_addr_q <= ram_raddr;
    end
    if (accept) begin
      func_q  <= func_i;
      cnt_q   <= block_count_i;
      start_q <= '0;
      lo_q    <= first_block_i;
      end_q   <= bcba_pkg::CNT_W'(range_sum);
      mw_q    <= first_block_i[bcba_pkg::BLK_W-1:bcba_pkg::BIT_W];
      case (func_i)
        bcba_pkg::FUNC_FREE:   ok_q <= range_ok;
        bcba_pkg::FUNC_STATUS: ok_q <= 1'b1;
        default:               ok_q <= 1'b0;
      endcase
    end
    if (state_q == bcba_pkg::ST_FIND_END) begin
      ok_q    <= scan_res.found;
      start_q <= scan_res.found ? scan_res.start : '0;
      lo_q    <= scan_res.start;
      end_q   <= {1'b0, scan_res.start} + cnt_q;
      mw_q    <= scan_res.start[bcba_pkg::BLK_W-1:bcba_pkg::BIT_W];
    end
    if ((state_q == bcba_pkg::ST_MARK_WR) && (mw_q != last_w)) begin
      mw_q <= mw_q + 1'b1;
    end
    if (state_q == bcba_pkg::ST_MUL) begin
      largest_q <= scan_res.best;
      zero_q    <= (free_q == '0) || (free_q < scan_res.best);
    end
    if (out_load) begin
      out_ok_q      <= ok_q;
      out_start_q   <= start_q;
      out_free_q    <= free_q;
      out_used_q    <= used_q;
      out_largest_q <= largest_q;
      out_frag_q    <= zero_q ? '0 : div_quot;
    end
  end

  bcba_ram #(
    .WIDTH(bcba_pkg::WORD_W),
    .DEPTH(bcba_pkg::NUM_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(mw_q),
    .wdata_i(mark_word),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bcba_scan u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(scan_ctrl),
    .word_i(word),
    .base_i(data_addr_q),
    .need_i(cnt_q),
    .res_o (scan_res)
  );

  bcba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (free_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_valid_o        = out_valid_q;
  assign ok_o               = out_ok_q;
  assign start_block_o      = out_start_q;
  assign free_count_o       = out_free_q;
  assign used_count_o       = out_used_q;
  assign largest_free_run_o = out_largest_q;
  assign fragment_pct_o     = out_frag_q;

  a_counters_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcba_pkg::RNG_W'(free_q) + bcba_pkg::RNG_W'(used_q)) ==
    bcba_pkg::RNG_W'(bcba_pkg::NUM_BLOCKS))
    else $error("free and used counters do not add up to the map size");

  a_alloc_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcba_pkg::ST_MARK_WR) && (func_q == bcba_pkg::FUNC_ALLOC) |->
    ((mark_mask & word) == '0))
    else $error("allocation marks a block that is already used");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == bcba_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_alloc_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcba_pkg::ST_DONE) && (func_q == bcba_pkg::FUNC_ALLOC) && ok_q |->
    (({2'b00, start_q} + bcba_pkg::RNG_W'(cnt_q)) <= bcba_pkg::RNG_W'(bcba_pkg::NUM_BLOCKS)))
    else $error("allocated run runs past the end of the map");

  a_largest_le_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcba_pkg::ST_DONE) |-> (largest_q <= free_q))
    else $error("longest free run exceeds the free count");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the first-fit bitmap block allocator.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int         QUIET_LIMIT = 20000;
  localparam int         DRAIN_WAIT  = 600;
  localparam int         RANDOM_REQS = 1000;

  typedef struct packed {
    logic [1:0]                 fn;
    logic [bcba_pkg::CNT_W-1:0] cnt;
    logic [bcba_pkg::BLK_W-1:0] first;
    logic                       drain;
  } request_t;

  typedef struct packed {
    logic                        ok;
    logic [bcba_pkg::BLK_W-1:0]  start;
    logic [bcba_pkg::CNT_W-1:0]  free_n;
    logic [bcba_pkg::CNT_W-1:0]  used_n;
    logic [bcba_pkg::CNT_W-1:0]  run_n;
    logic [bcba_pkg::FRAC_W-1:0] frag;
  } outcome_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid      = 1'b0;
  logic [1:0]                  func          = bcba_pkg::FUNC_STATUS;
  logic [bcba_pkg::CNT_W-1:0]  block_count   = '0;
  logic [bcba_pkg::BLK_W-1:0]  first_block   = '0;
  logic                        out_stall     = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic                        ok_o;
  logic [bcba_pkg::BLK_W-1:0]  start_block_o;
  logic [bcba_pkg::CNT_W-1:0]  free_count_o;
  logic [bcba_pkg::CNT_W-1:0]  used_count_o;
  logic [bcba_pkg::CNT_W-1:0]  largest_free_run_o;
  logic [bcba_pkg::FRAC_W-1:0] fragment_pct_o;

  logic [bcba_pkg::NUM_BLOCKS-1:0] occ_map = '0;
  int                    n_free  = bcba_pkg::NUM_BLOCKS;
  int                    n_used  = 0;
  int                    peak_used = 0;

  request_t request_q[$];
  outcome_t outcome_q[$];
  request_t next_req;
  outcome_t seen;
  int       burst_left = 1;
  int       gap_left   = 0;
  int       stall_mode = 0;
  int       pattern_left = 0;
  int       quiet      = 0;
  int       errors     = 0;
  int       n_sent     = 0;
  int       n_checked  = 0;
  int       n_granted  = 0;
  int       n_refused  = 0;

  bitmap_contiguous_block_allocator_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .func_i             (func),
    .block_count_i      (block_count),
    .first_block_i      (first_block),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .ok_o               (ok_o),
    .start_block_o      (start_block_o),
    .free_count_o       (free_count_o),
    .used_count_o       (used_count_o),
    .largest_free_run_o (largest_free_run_o),
    .fragment_pct_o     (fragment_pct_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic outcome_t allocator_outcome(input logic [1:0] fn,
                                                 input logic [bcba_pkg::CNT_W-1:0] cnt,
                                                 input logic [bcba_pkg::BLK_W-1:0] first);
    outcome_t    res;
    int          run;
    int          best;
    int          start_at;
    bit          found;
    int unsigned frag;
    res      = '0;
    found    = 1'b0;
    start_at = 0;
    case (fn)
      bcba_pkg::FUNC_ALLOC: begin
        run = 0;
        if (cnt != 0) begin
          for (int i = 0; i < bcba_pkg::NUM_BLOCKS && !found; i++) begin
            if (!occ_map[i]) begin
              run++;
              if (run == int'(cnt)) begin
                found    = 1'b1;
                start_at = i + 1 - int'(cnt);
              end
            end else begin
              run = 0;
            end
          end
        end
        if (found) begin
          for (int i = start_at; i < start_at + int'(cnt); i++) occ_map[i] = 1'b1;
          n_used += int'(cnt);
          n_free -= int'(cnt);
          res.ok    = 1'b1;
          res.start = start_at[bcba_pkg::BLK_W-1:0];
        end
      end
      bcba_pkg::FUNC_FREE: begin
        if (int'(first) + int'(cnt) <= bcba_pkg::NUM_BLOCKS) begin
          for (int i = int'(first); i < int'(first) + int'(cnt); i++) begin
            if (occ_map[i]) begin
              occ_map[i] = 1'b0;
              n_used--;
              n_free++;
            end
          end
          res.ok = 1'b1;
        end
      end
      bcba_pkg::FUNC_STATUS: res.ok = 1'b1;
      default:               res.ok = 1'b0;
    endcase
    best = 0;
    run  = 0;
    for (int i = 0; i < bcba_pkg::NUM_BLOCKS; i++) begin
      if (!occ_map[i]) begin
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    frag = 0;
    if (n_free != 0 && n_free >= best)
      frag = (unsigned'(n_free - best) * unsigned'(bcba_pkg::PCT_SCALE)) / unsigned'(n_free);
    if (n_used > peak_used) peak_used = n_used;
    res.free_n = n_free[bcba_pkg::CNT_W-1:0];
    res.used_n = n_used[bcba_pkg::CNT_W-1:0];
    res.run_n  = best[bcba_pkg::CNT_W-1:0];
    res.frag   = frag[bcba_pkg::FRAC_W-1:0];
    return res;
  endfunction

  function automatic void compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic push_request(input logic [1:0] fn, input int cnt, input int first,
                              input bit drain = 1'b0);
    request_t r;
    r.fn    = fn;
    r.cnt   = cnt[bcba_pkg::CNT_W-1:0];
    r.first = first[bcba_pkg::BLK_W-1:0];
    r.drain = drain;
    request_q.push_back(r);
  endtask

  // Sender: hold the request until taken, then advance in bursts with gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        outcome_q.push_back(allocator_outcome(func, block_count, first_block));
        n_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (request_q[0].drain && outcome_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          next_req    = request_q.pop_front();
          in_valid    <= 1'b1;
          func        <= next_req.fn;
          block_count <= next_req.cnt;
          first_block <= next_req.first;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 9: gap_left = 0;
              8:             gap_left = $urandom_range(41, 700);
              default:       gap_left = $urandom_range(1, 40);
            endcase
          end
        end
      end
    end
  end

  // Receiver: check each result against the oldest outstanding prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          seen = outcome_q.pop_front();
          compare_field("ok", int'(seen.ok), int'(ok_o));
          compare_field("start_block", int'(seen.start), int'(start_block_o));
          compare_field("free_count", int'(seen.free_n), int'(free_count_o));
          compare_field("used_count", int'(seen.used_n), int'(used_count_o));
          compare_field("largest_free_run", int'(seen.run_n), int'(largest_free_run_o));
          compare_field("fragment_pct", int'(seen.frag), int'(fragment_pct_o));
          n_checked++;
          if (seen.ok) n_granted++;
          else n_refused++;
        end
      end
      if (pattern_left == 0) begin
        stall_mode   = $urandom_range(0, 2);
        pattern_left = $urandom_range(20, 400);
      end else begin
        pattern_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL bitmap_contiguous_block_allocator_unit");
        $finish;
      end
    end
  end

  initial begin
    int fn_pick;
    int first;
    int cnt;
    push_request(bcba_pkg::FUNC_STATUS, 0, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 0, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 2047, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 1025, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 1024, 0);
    push_request(bcba_pkg::FUNC_STATUS, 0, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 1, 0);
    push_request(bcba_pkg::FUNC_FREE, 1, 1023);
    push_request(bcba_pkg::FUNC_ALLOC, 1, 0);
    push_request(bcba_pkg::FUNC_FREE, 2, 1023);
    push_request(bcba_pkg::FUNC_FREE, 0, 1023);
    push_request(bcba_pkg::FUNC_FREE, 1024, 0, 1'b1);
    push_request(bcba_pkg::FUNC_FREE, 1024, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 3, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 5, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 2, 0);
    push_request(bcba_pkg::FUNC_FREE, 5, 3);
    push_request(bcba_pkg::FUNC_ALLOC, 6, 0);
    push_request(bcba_pkg::FUNC_ALLOC, 4, 0);
    push_request(FUNC_SPARE, 2047, 1023);
    push_request(bcba_pkg::FUNC_FREE, 512, 512);
    push_request(bcba_pkg::FUNC_FREE, 2047, 0);
    push_request(bcba_pkg::FUNC_FREE, 0, 1);
    push_request(bcba_pkg::FUNC_STATUS, 2047, 1023, 1'b1);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      fn_pick = $urandom_range(0, 99);
      if (fn_pick < 45) begin
        if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 2047);
        else if ($urandom_range(0, 9) == 0) cnt = $urandom_range(17, 300);
        else cnt = $urandom_range(1, 16);
        push_request(bcba_pkg::FUNC_ALLOC, cnt, $urandom_range(0, 1023), (n % 97) == 96);
      end else if (fn_pick < 85) begin
        first = $urandom_range(0, 1023);
        if ($urandom_range(0, 49) == 0) begin
          first = 0;
          cnt   = bcba_pkg::NUM_BLOCKS;
        end else if ($urandom_range(0, 14) == 0) begin
          cnt = $urandom_range(0, 2047);
        end else begin
          cnt = $urandom_range(0, (bcba_pkg::NUM_BLOCKS - first < 48) ?
                                  bcba_pkg::NUM_BLOCKS - first : 48);
        end
        push_request(bcba_pkg::FUNC_FREE, cnt, first, (n % 97) == 96);
      end else if (fn_pick < 95) begin
        push_request(bcba_pkg::FUNC_STATUS, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else begin
        push_request(FUNC_SPARE, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d results for %0d requests: %0d succeeded, %0d refused.",
             n_checked, n_sent, n_granted, n_refused);
    $display("Map occupancy peaked at %0d of %0d blocks.", peak_used, bcba_pkg::NUM_BLOCKS);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("PASS bitmap_contiguous_block_allocator_unit");
    end else begin
      $display("FAIL bitmap_contiguous_block_allocator_unit");
    end
    $finish;
  end

endmodule
